// ===== hw/rtl/rsa_pkg.sv =====
// Package: constants and types for region_stats_adjacency
package rsa_pkg;
	localparam int MaxRegions = 1024;
	localparam int MaxColumns = 4096;
	localparam int MaxRows    = 4096;
	localparam int LabW  = 10;
	localparam int ColW  = 12;
	localparam int CntW  = 25;
	localparam int SumW  = 41;
	localparam int SqW   = 57;
	localparam int PosW  = 36;
	localparam logic [CntW-1:0] CountLimit = '1;

	localparam logic [0:0] KindPixel = 1'b0;
	localparam logic [0:0] KindRead  = 1'b1;
	localparam logic [0:0] CfgColumns = 1'b0;
	localparam logic [0:0] CfgRows    = 1'b1;

	typedef struct packed {
		logic [CntW-1:0] cnt;
		logic [SumW-1:0] sum;
		logic [SqW-1:0]  sq;
		logic [PosW-1:0] rsum;
		logic [PosW-1:0] csum;
	} stats_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_PIX, ST_RD, ST_MUL, ST_SUB, ST_DIV, ST_OUT
	} state_t;
endpackage

// ===== hw/rtl/region_stats_adjacency.sv =====
// Top level: region moments and adjacency edge stream
// Usage: pixels (kind 0) arrive in row-major order on in_valid/in_ready; each
// gives an edge transaction per left or up neighbour with another non-zero
// label, left first, on out_valid/out_ready, the final one flagged by last.
// A readout (kind 1) returns one statistics transaction and clears that region.
// A pixel passes through a read of the region memory and the previous-row
// label memory, a write back of both, then the output register, which it
// loads once per edge. The first result is loaded once that register is free.
// A readout runs six steps on one 32 x 32 multiplier, then, when the region
// is not empty, four divisions (mean, variance, both centroids) on a shared
// bit-serial divider.
// After reset a clearing pass zeroes all 1024 entries of the region memory;
// no item is accepted during it. Configuration writes are taken anytime.
// A stalled receiver holds the output register; the next result waits in
// the block, and no input is taken until it is loaded.
module region_stats_adjacency import rsa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [9:0]  label,
	input  logic [15:0] height,
	input  logic [9:0]  region_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [9:0]  edge_low,
	output logic [9:0]  edge_high,
	output logic [24:0] pixel_count,
	output logic [15:0] mean_height,
	output logic [31:0] height_variance,
	output logic [19:0] centroid_row,
	output logic [19:0] centroid_col,
	output logic        last
);
	stats_t        smem [MaxRegions];
	logic [LabW-1:0] lmem [MaxColumns];
	stats_t        srd_q;
	logic [LabW-1:0] up_q;

	state_t st_q, st_d;
	logic [12:0] cols_q, rows_q;
	logic [ColW-1:0] col_q, row_q;
	logic [LabW-1:0] left_q, lab_q, idx_q, clr_q;
	logic [15:0] h_q;
	logic kind_q;
	logic e1_q, e2_q;
	logic [LabW-1:0] e1a_q, e2a_q, ea;
	logic [127:0] a_q, b_q, vnum_q;
	logic [63:0]  ccsq_q;
	logic [2:0]   mstep_q;
	logic [1:0]   step_q;
	logic         run_q;
	logic         dstart, div_done;
	logic [127:0] dnum, dquo;
	logic [63:0]  dden;
	logic         dbusy;
	logic [31:0]  mx, my;
	logic [63:0]  pp;
	logic [15:0]  mean_q;
	logic [31:0]  var_q;
	logic [19:0]  crow_q, ccol_q;
	logic         out_free, out_load, out_pend;

	logic [12:0] ncols, nrows;
	always_comb begin
		ncols = (cols_q == 13'd0) ? 13'd1 : (cols_q > 13'(MaxColumns) ? 13'(MaxColumns) : cols_q);
		nrows = (rows_q == 13'd0) ? 13'd1 : (rows_q > 13'(MaxRows) ? 13'(MaxRows) : rows_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 13'd4096;
			rows_q <= 13'd4096;
		end else if (cfg_we) begin
			if (cfg_index == CfgColumns) cols_q <= cfg_data;
			else rows_q <= cfg_data;
		end
	end

	rsa_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.busy(dbusy), .quo(dquo)
	);

	assign out_free = !out_valid || out_ready;
	assign out_pend = (kind_q == KindRead) || e1_q || e2_q;
	assign out_load = (st_q == ST_OUT) && out_free && out_pend;
	assign in_ready = (st_q == ST_IDLE);

	logic cnz;
	assign cnz = srd_q.cnt != '0;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:  if (in_valid) st_d = (kind == KindRead) ? ST_RD : ST_PIX;
			ST_CLEAR: if (clr_q == LabW'(MaxRegions-1)) st_d = ST_IDLE;
			ST_PIX:   st_d = ST_OUT;
			ST_RD:    st_d = ST_MUL;
			ST_MUL:   if (mstep_q == 3'd5) st_d = ST_SUB;
			ST_SUB:   st_d = cnz ? ST_DIV : ST_OUT;
			ST_DIV:   if (div_done && step_q == 2'd3) st_d = ST_OUT;
			ST_OUT:   if (!out_pend || (out_free && !(e1_q && e2_q))) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// saturated and clipped quotient helpers
	logic [31:0] q32;
	logic [19:0] q20;
	always_comb begin
		q32 = (dquo[127:32] != '0) ? 32'hFFFF_FFFF : dquo[31:0];
		q20 = (dquo[127:20] != '0) ? 20'hFFFFF : dquo[19:0];
	end

	logic pix_lab_ok;
	assign pix_lab_ok = (lab_q != '0);
	logic upd;
	assign upd = pix_lab_ok && (srd_q.cnt != CountLimit);
	logic le, ue;
	assign le = pix_lab_ok && col_q != '0 && left_q != '0 && left_q != lab_q;
	assign ue = pix_lab_ok && row_q != '0 && up_q != '0 && up_q != lab_q;
	assign ea = e1_q ? e1a_q : e2a_q;

	// one 32 x 32 product per step: cnt*sq in two parts, sum*sum in three, cnt*cnt
	always_comb begin
		case (mstep_q)
			3'd0: begin mx = 32'(srd_q.cnt); my = srd_q.sq[31:0]; end
			3'd1: begin mx = 32'(srd_q.cnt); my = 32'(srd_q.sq[SqW-1:32]); end
			3'd2: begin mx = srd_q.sum[31:0]; my = srd_q.sum[31:0]; end
			3'd3: begin mx = srd_q.sum[31:0]; my = 32'(srd_q.sum[SumW-1:32]); end
			3'd4: begin mx = 32'(srd_q.sum[SumW-1:32]); my = 32'(srd_q.sum[SumW-1:32]); end
			default: begin mx = 32'(srd_q.cnt); my = 32'(srd_q.cnt); end
		endcase
		pp = 64'(mx) * 64'(my);
	end

	assign dstart = (st_q == ST_DIV) && !run_q;
	assign div_done = run_q && !dbusy;

	always_comb begin
		dden = {39'd0, srd_q.cnt};
		case (step_q)
			2'd0: dnum = {87'd0, srd_q.sum};
			2'd1: begin dnum = vnum_q; dden = ccsq_q; end
			2'd2: dnum = {84'd0, srd_q.rsum, 8'd0};
			default: dnum = {84'd0, srd_q.csum, 8'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			col_q <= '0;
			row_q <= '0;
			left_q <= '0;
			out_valid <= 1'b0;
			e1_q <= 1'b0;
			e2_q <= 1'b0;
			mstep_q <= '0;
			step_q <= '0;
			run_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == ST_PIX) begin
				left_q <= lab_q;
				if (32'(col_q) + 1 >= 32'(ncols)) begin
					col_q <= '0;
					row_q <= (32'(row_q) + 1 >= 32'(nrows)) ? '0 : row_q + 1'b1;
				end else col_q <= col_q + 1'b1;
				e1_q <= le || ue;
				e2_q <= le && ue;
			end else if (out_load) begin
				if (e1_q) e1_q <= 1'b0;
				else e2_q <= 1'b0;
			end
			if (st_q == ST_MUL) mstep_q <= mstep_q + 1'b1;
			else mstep_q <= '0;
			if (st_q == ST_SUB) step_q <= '0;
			else if (div_done) step_q <= step_q + 1'b1;
			if (dstart) run_q <= 1'b1;
			else if (div_done) run_q <= 1'b0;
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && in_valid) begin
			kind_q <= kind;
			lab_q <= (kind == KindRead) ? '0 : label;
			h_q <= height;
			idx_q <= region_index;
		end
		if (st_q == ST_IDLE) begin
			srd_q <= smem[(kind == KindRead) ? region_index : label];
			up_q <= lmem[col_q];
		end else if (st_q == ST_RD && idx_q == '0) srd_q <= '0;
		if (st_q == ST_CLEAR) smem[clr_q] <= '0;
		else if (st_q == ST_PIX) begin
			lmem[col_q] <= lab_q;
			if (upd) smem[lab_q] <= '{
				cnt: srd_q.cnt + 1'b1,
				sum: srd_q.sum + SumW'(h_q),
				sq: srd_q.sq + SqW'(32'(h_q) * 32'(h_q)),
				rsum: srd_q.rsum + PosW'(row_q),
				csum: srd_q.csum + PosW'(col_q)};
		end else if (st_q == ST_RD && idx_q != '0) smem[idx_q] <= '0;
		if (st_q == ST_PIX) begin
			e1a_q <= le ? left_q : up_q;
			e2a_q <= up_q;
		end
		if (st_q == ST_MUL) begin
			case (mstep_q)
				3'd0: a_q <= 128'(pp);
				3'd1: a_q <= a_q + {32'd0, pp, 32'd0};
				3'd2: b_q <= 128'(pp);
				3'd3: b_q <= b_q + {31'd0, pp, 33'd0};
				3'd4: b_q <= b_q + {pp, 64'd0};
				default: ccsq_q <= pp;
			endcase
		end
		if (st_q == ST_SUB) begin
			vnum_q <= (a_q > b_q) ? a_q - b_q : '0;
			mean_q <= '0; var_q <= '0; crow_q <= '0; ccol_q <= '0;
		end else if (div_done) begin
			case (step_q)
				2'd0: mean_q <= dquo[15:0];
				2'd1: var_q <= q32;
				2'd2: crow_q <= q20;
				default: ccol_q <= q20;
			endcase
		end
		if (out_load) begin
			result_kind <= kind_q;
			edge_low <= (kind_q == KindRead) ? '0 : ((ea < lab_q) ? ea : lab_q);
			edge_high <= (kind_q == KindRead) ? '0 : ((ea < lab_q) ? lab_q : ea);
			pixel_count <= (kind_q == KindRead) ? srd_q.cnt : '0;
			mean_height <= (kind_q == KindRead) ? mean_q : '0;
			height_variance <= (kind_q == KindRead) ? var_q : '0;
			centroid_row <= (kind_q == KindRead) ? crow_q : '0;
			centroid_col <= (kind_q == KindRead) ? ccol_q : '0;
			last <= !(e1_q && e2_q);
		end
	end
endmodule

// ===== hw/rtl/rsa_divider.sv =====
// Module: bit-serial restoring divider, 128-bit numerator, 64-bit divisor
module rsa_divider import rsa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] num,
	input  logic [63:0]  den,
	output logic         busy,
	output logic [127:0] quo
);
	logic [127:0] n_q;
	logic [64:0]  rem_q;
	logic [7:0]   cnt_q;
	logic [64:0]  sh;
	logic         ge;

	assign sh = {rem_q[63:0], n_q[127]};
	assign ge = sh >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= 8'd128;
		end else if (busy) begin
			cnt_q <= cnt_q - 8'd1;
			if (cnt_q == 8'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			rem_q <= '0;
			quo   <= '0;
		end else if (busy) begin
			n_q   <= {n_q[126:0], 1'b0};
			rem_q <= ge ? sh - {1'b0, den} : sh;
			quo   <= {quo[126:0], ge};
		end
	end
endmodule

// ===== verif/region_stats_adjacency_tb.sv =====
// Testbench for region_stats_adjacency: directed and random pixel/readout stream with scoreboard
`timescale 1ns / 100ps

module region_stats_adjacency_tb import rsa_pkg::*; ();

	typedef struct {
		logic        rkind;
		logic [9:0]  lo;
		logic [9:0]  hi;
		logic [24:0] cnt;
		logic [15:0] mean;
		logic [31:0] vari;
		logic [19:0] crow;
		logic [19:0] ccol;
		logic        lst;
	} result_t;

	class region_scoreboard;
		result_t     expected_q[$];
		int          errors;
		logic [24:0] cnt_m [MaxRegions];
		logic [40:0] sum_m [MaxRegions];
		logic [56:0] sq_m  [MaxRegions];
		logic [35:0] rsum_m[MaxRegions];
		logic [35:0] csum_m[MaxRegions];
		logic [9:0]  prev_row[MaxColumns];
		bit          prev_written[MaxColumns];
		logic [9:0]  left_lab;
		int          col, row, ncols, nrows;

		function new();
			foreach (cnt_m[i]) begin
				cnt_m[i] = 0; sum_m[i] = 0; sq_m[i] = 0; rsum_m[i] = 0; csum_m[i] = 0;
			end
			foreach (prev_written[i]) prev_written[i] = 0;
			left_lab = 0; col = 0; row = 0; ncols = 4096; nrows = 4096;
		endfunction

		function void set_reg(logic [0:0] idx, int value);
			int v;
			v = value & 13'h1FFF;
			if (v < 1) v = 1;
			if (v > 4096) v = 4096;
			if (idx == CfgColumns) ncols = v;
			else nrows = v;
		endfunction

		// a non-background pixel here would read an upper label never stored
		function bit upper_unknown();
			return row > 0 && !prev_written[col];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push_edge(logic [9:0] a, logic [9:0] b);
			result_t r;
			r = '{default: 0};
			r.lo = a < b ? a : b;
			r.hi = a < b ? b : a;
			expected_q.push_back(r);
		endfunction

		function void note_input(logic k, logic [9:0] lab, logic [15:0] h, logic [9:0] idx);
			result_t     r;
			logic [127:0] a, b, q, c, t;
			int          n0;
			if (k == KindRead) begin
				r = '{default: 0};
				r.rkind = 1; r.lst = 1;
				if (idx != 0) begin
					c = 128'(cnt_m[idx]);
					r.cnt = cnt_m[idx];
					if (c != 0) begin
						r.mean = 16'(128'(sum_m[idx]) / c);
						a = c * 128'(sq_m[idx]);
						b = 128'(sum_m[idx]);
						b = b * b;
						if (a > b) begin
							q = (a - b) / (c * c);
							r.vari = q > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
						end
						t = {84'd0, rsum_m[idx], 8'b0} / c;
						r.crow = t > 128'hFFFFF ? 20'hFFFFF : t[19:0];
						t = {84'd0, csum_m[idx], 8'b0} / c;
						r.ccol = t > 128'hFFFFF ? 20'hFFFFF : t[19:0];
					end
					cnt_m[idx] = 0; sum_m[idx] = 0; sq_m[idx] = 0;
					rsum_m[idx] = 0; csum_m[idx] = 0;
				end
				expected_q.push_back(r);
				return;
			end
			n0 = expected_q.size();
			if (lab != 0) begin
				if (cnt_m[lab] != CountLimit) begin
					cnt_m[lab] += 1'b1;
					sum_m[lab] += 41'(h);
					sq_m[lab] += 57'(h) * 57'(h);
					rsum_m[lab] += 36'(row);
					csum_m[lab] += 36'(col);
				end
				if (col > 0 && left_lab != 0 && left_lab != lab) push_edge(left_lab, lab);
				if (row > 0 && prev_row[col] != 0 && prev_row[col] != lab)
					push_edge(prev_row[col], lab);
			end
			prev_row[col] = lab;
			prev_written[col] = 1;
			left_lab = lab;
			col++;
			if (col >= ncols) begin
				col = 0;
				row++;
				if (row >= nrows) row = 0;
			end
			if (expected_q.size() > n0) expected_q[expected_q.size()-1].lst = 1;
		endfunction

		function void report(string f, longint e, longint a);
			errors++;
			$display("%0t mismatch %s: expected %0d actual %0d", $time, f, e, a);
		endfunction

		function void check_result(result_t act);
			result_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t unexpected result transaction: kind %0d", $time, act.rkind);
				return;
			end
			e = expected_q.pop_front();
			if (e.rkind !== act.rkind) report("result_kind", e.rkind, act.rkind);
			if (e.lo !== act.lo) report("edge_low", e.lo, act.lo);
			if (e.hi !== act.hi) report("edge_high", e.hi, act.hi);
			if (e.cnt !== act.cnt) report("pixel_count", e.cnt, act.cnt);
			if (e.mean !== act.mean) report("mean_height", e.mean, act.mean);
			if (e.vari !== act.vari) report("height_variance", e.vari, act.vari);
			if (e.crow !== act.crow) report("centroid_row", e.crow, act.crow);
			if (e.ccol !== act.ccol) report("centroid_col", e.ccol, act.ccol);
			if (e.lst !== act.lst) report("last", e.lst, act.lst);
		endfunction
	endclass

	logic        clk, arst_n, cfg_we;
	logic [0:0]  cfg_index;
	logic [12:0] cfg_data;
	logic        in_valid, in_ready, kind;
	logic [9:0]  label, region_index;
	logic [15:0] height;
	logic        out_valid, out_ready, result_kind, last;
	logic [9:0]  edge_low, edge_high;
	logic [24:0] pixel_count;
	logic [15:0] mean_height;
	logic [31:0] height_variance;
	logic [19:0] centroid_row, centroid_col;

	region_scoreboard sb;
	bit  calm;
	longint cycles;

	region_stats_adjacency dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 5000000) begin
			$display("region_stats_adjacency_tb: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 30);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{result_kind, edge_low, edge_high, pixel_count, mean_height,
				height_variance, centroid_row, centroid_col, last});
	end

	task automatic write_reg(logic [0:0] idx, int value);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= value[12:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic send(logic k, logic [9:0] lab, logic [15:0] h, logic [9:0] idx);
		if (k == KindPixel && sb.upper_unknown()) lab = 0;
		in_valid <= 1'b1; kind <= k; label <= lab; height <= h; region_index <= idx;
		do @(posedge clk); while (!in_ready);
		sb.note_input(k, lab, h, idx);
		if (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic random_item();
		logic [9:0] lab;
		int p;
		p = $urandom_range(99);
		if (p < 60) lab = 10'($urandom_range(1, 6));
		else if (p < 80) lab = 0;
		else lab = 10'($urandom);
		if ($urandom_range(99) < 12)
			send(KindRead, 10'($urandom), 16'($urandom),
				$urandom_range(99) < 70 ? 10'($urandom_range(1, 6)) : 10'($urandom));
		else
			send(KindPixel, lab, 16'($urandom), 10'($urandom));
	endtask

	int phase_cols[8] = '{16, 1, 7, 0, 8191, 5, 3, 4096};
	int phase_rows[8] = '{8, 5, 1, 0, 2, 8191, 4096, 3};

	initial begin
		sb = new();
		clk = 0; arst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; kind = 0; label = 0; height = 0; region_index = 0;
		out_ready = 0; calm = 0; cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_reg(CfgColumns, 4);
		write_reg(CfgRows, 3);
		// 4x3 grid: left, up, both, same label, background, row wrap
		send(KindPixel, 1, 16'hFFFF, 0);
		send(KindPixel, 1, 0, 10'h3FF);
		send(KindPixel, 2, 16'h0100, 0);
		send(KindPixel, 0, 16'hFFFF, 0);
		send(KindPixel, 3, 16'h8000, 0);
		send(KindPixel, 2, 16'h0001, 0);
		send(KindPixel, 2, 16'hFFFF, 0);
		send(KindPixel, 1, 16'h1234, 0);
		send(KindPixel, 1023, 16'hFFFF, 0);
		send(KindPixel, 0, 0, 0);
		send(KindPixel, 5, 16'h00FF, 0);
		send(KindPixel, 5, 16'hFF00, 0);
		send(KindPixel, 5, 16'h0200, 0);
		send(KindPixel, 1, 16'h0300, 0);
		send(KindRead, 0, 0, 1);
		send(KindRead, 10'h3FF, 16'hFFFF, 2);
		send(KindRead, 0, 0, 3);
		send(KindRead, 0, 0, 1023);
		send(KindRead, 0, 0, 0);
		send(KindRead, 0, 0, 7);
		send(KindRead, 0, 0, 5);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CfgColumns, phase_cols[ph]);
			write_reg(CfgRows, phase_rows[ph]);
			calm = (ph == 2);
			for (int i = 0; i < 130; i++) begin
				if (ph == 5 && i == 60) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (sb.pending() != 0) @(posedge clk);
				end
				random_item();
			end
			calm = 0;
			drain();
		end
		if (sb.errors == 0 && sb.pending() == 0)
			$display("region_stats_adjacency_tb: done, clean");
		else
			$display("region_stats_adjacency_tb: done, errors");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/rsa_pkg.sv
hw/rtl/rsa_divider.sv
hw/rtl/region_stats_adjacency.sv
verif/region_stats_adjacency_tb.sv
